// ===== sv/tws_pkg.sv =====
package tws_pkg;

   // sequence store
   localparam int SEQ_DEPTH = 4096;
   localparam int ADDR_W = $clog2(SEQ_DEPTH);
   localparam int CNT_W = $clog2(SEQ_DEPTH + 1);
   localparam int EVENT_W = 32;
   localparam int DELAY_W = 16;

   // millisecond to tick conversion
   localparam int ELAPSED_W = 16;
   localparam int TICK_RATE = 70;
   localparam int MS_PER_SEC = 1000;
   localparam int REM_W = 10;
   localparam int ACC_W = 23;
   localparam int TICK_W = 13;
   localparam int TIME_W = 32;
   // floor(acc / 1000) == (acc * RECIP) >> RECIP_SHIFT for every acc below 2**ACC_W
   localparam int RECIP_W = 24;
   localparam logic [RECIP_W-1:0] RECIP = 24'd8589935;
   localparam int RECIP_SHIFT = 33;
   localparam int PROD_W = ACC_W + RECIP_W;

   // writes per poll
   localparam int MAX_WRITES = 64;
   localparam int WCNT_W = $clog2(MAX_WRITES + 1);

   // silencing writes
   localparam logic [7:0] REG_EFFECTS = 8'hBD;
   localparam logic [7:0] REG_KEYON_BASE = 8'hB0;
   localparam int KEYON_CHANNELS = 9;
   localparam int SIL_W = 4;

   // config registers
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIRS = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_POLL  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_SCAN,
      S_EMIT,
      S_FINISH,
      S_SIL
   } state_type;

endpackage

// ===== sv/tws_ram.sv =====
module tws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/timed_register_write_sequencer_top.sv =====
// Plays a looping sequence of (register, value, delay) events as synthesizer
// register writes. Commands are taken when start is high and busy is low.
// Load writes one slot of the 4096-word sequence store (slots never loaded
// must not be played). Start and stop complete without writes when nothing
// plays, else issue ten silencing writes (0xBD, then 0xB0..0xB8, all value
// 0), one per cycle. A poll does the ms-to-tick conversion (multiply-add,
// reciprocal divide, remainder), then up to 64 writes with one store read
// per write on the single read port, then closes out the poll. Writes come
// out one per cycle on rsp_strobe and cannot be held off; rsp_last_write
// marks the final write of a command. The store has no reset and no clearing
// pass. Config writes are always taken (csr_ready is high) and must only be
// issued while the block is idle.
module timed_register_write_sequencer_top
   import tws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [11:0]           req_load_index,
   input  logic [15:0]           req_register_and_value,
   input  logic [15:0]           req_delay_ticks,
   input  logic [15:0]           req_elapsed_ms,

   // write word channel
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_write_register,
   output logic [7:0]            rsp_write_value,
   output logic                  rsp_last_write,

   // config channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // --- control state ---
   state_type        state_ff, state_in;
   logic             playing_ff, playing_in;
   logic [ADDR_W-1:0] play_idx_ff, play_idx_in;
   logic [CNT_W-1:0] pairs_ff, pairs_in;
   logic [CNT_W-1:0] loop_len_ff, loop_len_in;
   logic [TIME_W-1:0] tick_time_ff, tick_time_in;
   logic [TIME_W-1:0] due_tick_ff, due_tick_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             mode_ff;
   logic [CNT_W-1:0] cfg_pairs_ff;

   // --- per-command working registers ---
   opcode_type       op_ff, op_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic             active_ff, active_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic [SIL_W-1:0] sil_cnt_ff, sil_cnt_in;

   // --- output word ---
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]       rsp_reg_ff, rsp_reg_in;
   logic [7:0]       rsp_val_ff, rsp_val_in;
   logic             rsp_last_ff, rsp_last_in;

   // --- store ports ---
   logic              st_wr_en;
   logic [EVENT_W-1:0] st_wr_data;
   logic              st_rd_en;
   logic [ADDR_W-1:0] st_rd_addr;
   logic [EVENT_W-1:0] st_rd_data;

   // --- datapath helpers ---
   logic              accept;
   opcode_type        req_op;
   logic [PROD_W-1:0] recip_prod;
   logic [ACC_W-1:0]  rem_full;
   logic [TIME_W-1:0] next_due;
   logic [CNT_W-1:0]  pairs_dec;
   logic [WCNT_W-1:0] wcnt_inc;
   logic              emit_more;
   logic [CNT_W-1:0]  len_sat;

   assign accept = start && !busy;
   assign req_op = opcode_type'(req_opcode);
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // load writes land directly; every 12-bit slot is inside the store
   assign st_wr_en = accept && (req_op == OP_LOAD);
   assign st_wr_data = {req_delay_ticks, req_register_and_value};

   tws_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (SEQ_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (req_load_index[ADDR_W-1:0]),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // ticks = acc / 1000 by reciprocal; remainder back out by one constant multiply
   assign recip_prod = PROD_W'(acc_ff) * PROD_W'(RECIP);
   assign rem_full = acc_ff - ACC_W'(ticks_ff) * ACC_W'(MS_PER_SEC);

   // event read this cycle schedules the next one; due test is unsigned with wrap
   assign next_due = tick_time_ff + TIME_W'(st_rd_data[EVENT_W-1 -: DELAY_W]);
   assign pairs_dec = pairs_ff - CNT_W'(1);
   assign wcnt_inc = wcnt_ff + WCNT_W'(1);
   assign emit_more = (pairs_dec != '0) && (next_due <= tick_time_ff)
                      && (wcnt_inc < WCNT_W'(MAX_WRITES));

   // loop length saturates at the store depth
   assign len_sat = (cfg_pairs_ff > CNT_W'(SEQ_DEPTH)) ? CNT_W'(SEQ_DEPTH) : cfg_pairs_ff;

   always_comb begin
      state_in = state_ff;
      playing_in = playing_ff;
      play_idx_in = play_idx_ff;
      pairs_in = pairs_ff;
      loop_len_in = loop_len_ff;
      tick_time_in = tick_time_ff;
      due_tick_in = due_tick_ff;
      rem_in = rem_ff;
      op_in = op_ff;
      acc_in = acc_ff;
      ticks_in = ticks_ff;
      active_in = active_ff;
      wcnt_in = wcnt_ff;
      sil_cnt_in = sil_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_reg_in = rsp_reg_ff;
      rsp_val_in = rsp_val_ff;
      rsp_last_in = 1'b0;
      st_rd_en = 1'b0;
      st_rd_addr = play_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_op)
                  OP_START, OP_STOP: begin
                     op_in = req_op;
                     if (playing_ff) begin
                        sil_cnt_in = '0;
                        state_in = S_SIL;
                     end else if (req_op == OP_START && mode_ff) begin
                        loop_len_in = len_sat;
                        pairs_in = len_sat;
                        play_idx_in = '0;
                        tick_time_in = '0;
                        due_tick_in = '0;
                        playing_in = 1'b1;
                     end
                  end
                  OP_POLL: begin
                     acc_in = ACC_W'(rem_ff) + ACC_W'(req_elapsed_ms) * ACC_W'(TICK_RATE);
                     state_in = S_DIV;
                  end
                  default: begin
                     // load: handled on the store write port
                  end
               endcase
            end
         end

         S_DIV: begin
            ticks_in = recip_prod[RECIP_SHIFT +: TICK_W];
            state_in = S_SCAN;
         end

         S_SCAN: begin
            rem_in = rem_full[REM_W-1:0];
            active_in = playing_ff && (pairs_ff != '0);
            wcnt_in = '0;
            if (playing_ff && (pairs_ff != '0) && (due_tick_ff <= tick_time_ff)) begin
               st_rd_en = 1'b1;
               st_rd_addr = play_idx_ff;
               state_in = S_EMIT;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_reg_in = st_rd_data[7:0];
            rsp_val_in = st_rd_data[15:8];
            rsp_last_in = !emit_more;
            due_tick_in = next_due;
            play_idx_in = play_idx_ff + ADDR_W'(1);
            pairs_in = pairs_dec;
            wcnt_in = wcnt_inc;
            if (emit_more) begin
               // read ahead so the next event is ready next cycle
               st_rd_en = 1'b1;
               st_rd_addr = play_idx_ff + ADDR_W'(1);
            end else begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (active_ff) begin
               if (pairs_ff == '0) begin
                  // sequence ran out: loop back to slot 0 at time 0
                  play_idx_in = '0;
                  pairs_in = loop_len_ff;
                  tick_time_in = '0;
                  due_tick_in = '0;
               end else begin
                  tick_time_in = tick_time_ff + TIME_W'(ticks_ff);
               end
            end
            state_in = S_IDLE;
         end

         S_SIL: begin
            rsp_strobe_in = 1'b1;
            rsp_val_in = '0;
            if (sil_cnt_ff == '0) begin
               rsp_reg_in = REG_EFFECTS;
            end else begin
               rsp_reg_in = REG_KEYON_BASE + 8'(sil_cnt_ff - SIL_W'(1));
            end
            if (sil_cnt_ff == SIL_W'(KEYON_CHANNELS)) begin
               rsp_last_in = 1'b1;
               playing_in = 1'b0;
               if (op_ff == OP_START && mode_ff) begin
                  loop_len_in = len_sat;
                  pairs_in = len_sat;
                  play_idx_in = '0;
                  tick_time_in = '0;
                  due_tick_in = '0;
                  playing_in = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               sil_cnt_in = sil_cnt_ff + SIL_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         playing_ff <= 1'b0;
         play_idx_ff <= '0;
         pairs_ff <= '0;
         loop_len_ff <= '0;
         tick_time_ff <= '0;
         due_tick_ff <= '0;
         rem_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         playing_ff <= playing_in;
         play_idx_ff <= play_idx_in;
         pairs_ff <= pairs_in;
         loop_len_ff <= loop_len_in;
         tick_time_ff <= tick_time_in;
         due_tick_ff <= due_tick_in;
         rem_ff <= rem_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         cfg_pairs_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[0];
            CSR_PAIRS: cfg_pairs_ff <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      acc_ff <= acc_in;
      ticks_ff <= ticks_in;
      active_ff <= active_in;
      wcnt_ff <= wcnt_in;
      sil_cnt_ff <= sil_cnt_in;
      rsp_reg_ff <= rsp_reg_in;
      rsp_val_ff <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_write_register = rsp_reg_ff;
   assign rsp_write_value = rsp_val_ff;
   assign rsp_last_write = rsp_last_ff;

endmodule
